FILE: sv/scadec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scadec_pkg;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT  = 7'h36;
    localparam logic [6:0] KEY_CTRL    = 7'h1D;
    localparam logic [6:0] KEY_ALT     = 7'h38;
    localparam logic [6:0] KEY_CAPS    = 7'h3A;

    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [0:0] {
        EV_CHAR  = 1'b0,
        EV_COMBO = 1'b1
    } event_kind_t;

    // decoded key press handed from the front end to the back end
    typedef struct packed {
        logic [6:0] key;
        logic       shift;
        logic       caps;
        logic       combo;
        logic       ctrl;
        logic       alt;
    } key_op_t;

    function automatic logic [6:0] plain_char(input logic [6:0] key);
        logic [6:0] ch;
        ch = 7'h00;
        case (key)
            7'd1:  ch = 7'h1B;
            7'd2:  ch = 7'h31;
            7'd3:  ch = 7'h32;
            7'd4:  ch = 7'h33;
            7'd5:  ch = 7'h34;
            7'd6:  ch = 7'h35;
            7'd7:  ch = 7'h36;
            7'd8:  ch = 7'h37;
            7'd9:  ch = 7'h38;
            7'd10: ch = 7'h39;
            7'd11: ch = 7'h30;
            7'd12: ch = 7'h2D;
            7'd13: ch = 7'h3D;
            7'd14: ch = 7'h08;
            7'd15: ch = 7'h09;
            7'd16: ch = 7'h71;
            7'd17: ch = 7'h77;
            7'd18: ch = 7'h65;
            7'd19: ch = 7'h72;
            7'd20: ch = 7'h74;
            7'd21: ch = 7'h79;
            7'd22: ch = 7'h75;
            7'd23: ch = 7'h69;
            7'd24: ch = 7'h6F;
            7'd25: ch = 7'h70;
            7'd26: ch = 7'h5B;
            7'd27: ch = 7'h5D;
            7'd28: ch = 7'h0A;
            7'd30: ch = 7'h61;
            7'd31: ch = 7'h73;
            7'd32: ch = 7'h64;
            7'd33: ch = 7'h66;
            7'd34: ch = 7'h67;
            7'd35: ch = 7'h68;
            7'd36: ch = 7'h6A;
            7'd37: ch = 7'h6B;
            7'd38: ch = 7'h6C;
            7'd39: ch = 7'h3B;
            7'd40: ch = 7'h27;
            7'd41: ch = 7'h60;
            7'd43: ch = 7'h5C;
            7'd44: ch = 7'h7A;
            7'd45: ch = 7'h78;
            7'd46: ch = 7'h63;
            7'd47: ch = 7'h76;
            7'd48: ch = 7'h62;
            7'd49: ch = 7'h6E;
            7'd50: ch = 7'h6D;
            7'd51: ch = 7'h2C;
            7'd52: ch = 7'h2E;
            7'd53: ch = 7'h2F;
            7'd55: ch = 7'h2A;
            7'd57: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] shift_char(input logic [6:0] key);
        logic [6:0] ch;
        ch = 7'h00;
        case (key)
            7'd1:  ch = 7'h1B;
            7'd2:  ch = 7'h21;
            7'd3:  ch = 7'h40;
            7'd4:  ch = 7'h23;
            7'd5:  ch = 7'h24;
            7'd6:  ch = 7'h25;
            7'd7:  ch = 7'h5E;
            7'd8:  ch = 7'h26;
            7'd9:  ch = 7'h2A;
            7'd10: ch = 7'h28;
            7'd11: ch = 7'h29;
            7'd12: ch = 7'h5F;
            7'd13: ch = 7'h2B;
            7'd14: ch = 7'h08;
            7'd15: ch = 7'h09;
            7'd16: ch = 7'h51;
            7'd17: ch = 7'h57;
            7'd18: ch = 7'h45;
            7'd19: ch = 7'h52;
            7'd20: ch = 7'h54;
            7'd21: ch = 7'h59;
            7'd22: ch = 7'h55;
            7'd23: ch = 7'h49;
            7'd24: ch = 7'h4F;
            7'd25: ch = 7'h50;
            7'd26: ch = 7'h7B;
            7'd27: ch = 7'h7D;
            7'd28: ch = 7'h0A;
            7'd30: ch = 7'h41;
            7'd31: ch = 7'h53;
            7'd32: ch = 7'h44;
            7'd33: ch = 7'h46;
            7'd34: ch = 7'h47;
            7'd35: ch = 7'h48;
            7'd36: ch = 7'h4A;
            7'd37: ch = 7'h4B;
            7'd38: ch = 7'h4C;
            7'd39: ch = 7'h3A;
            7'd40: ch = 7'h22;
            7'd41: ch = 7'h7E;
            7'd43: ch = 7'h7C;
            7'd44: ch = 7'h5A;
            7'd45: ch = 7'h58;
            7'd46: ch = 7'h43;
            7'd47: ch = 7'h56;
            7'd48: ch = 7'h42;
            7'd49: ch = 7'h4E;
            7'd50: ch = 7'h4D;
            7'd51: ch = 7'h3C;
            7'd52: ch = 7'h3E;
            7'd53: ch = 7'h3F;
            7'd55: ch = 7'h2A;
            7'd57: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: sv/scadec_front.sv
`timescale 1ns / 1ps
`default_nettype none

module scadec_front
    import scadec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       scan_valid,
    input  wire logic [7:0] scan_byte,
    input  wire logic       q_full,
    output logic            scan_stall,
    output logic            push,
    output key_op_t         push_op
);

    logic prefix_reg, prefix_next;
    logic lshift_reg, lshift_next;
    logic rshift_reg, rshift_next;
    logic lctrl_reg, lctrl_next;
    logic rctrl_reg, rctrl_next;
    logic lalt_reg, lalt_next;
    logic ralt_reg, ralt_next;
    logic caps_reg, caps_next;

    logic       accept;
    logic       is_prefix;
    logic       ext;
    logic       make;
    logic       is_mod;
    logic [6:0] key;
    logic       shift;

    assign scan_stall = q_full;
    assign accept     = scan_valid && !q_full;
    assign is_prefix  = (scan_byte == PREFIX_BYTE);
    assign ext        = prefix_reg;
    assign make       = !scan_byte[7];
    assign key        = scan_byte[6:0];

    always_comb
    begin
        prefix_next = prefix_reg;
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        lctrl_next  = lctrl_reg;
        rctrl_next  = rctrl_reg;
        lalt_next   = lalt_reg;
        ralt_next   = ralt_reg;
        caps_next   = caps_reg;
        is_mod      = 1'b1;
        if (accept)
        begin
            if (is_prefix)
            begin
                prefix_next = 1'b1;
            end
            else
            begin
                prefix_next = 1'b0;
                if (!ext && key == KEY_LSHIFT)
                    lshift_next = make;
                else if (!ext && key == KEY_RSHIFT)
                    rshift_next = make;
                else if (!ext && key == KEY_CTRL)
                    lctrl_next = make;
                else if (ext && key == KEY_CTRL)
                    rctrl_next = make;
                else if (!ext && key == KEY_ALT)
                    lalt_next = make;
                else if (ext && key == KEY_ALT)
                    ralt_next = make;
                else if (!ext && key == KEY_CAPS)
                begin
                    if (make)
                        caps_next = !caps_reg;
                end
                else
                    is_mod = 1'b0;
            end
        end
    end

    // only plain make codes of ordinary keys go on to the lookup
    assign push  = accept && !is_prefix && make && !is_mod && !ext;
    assign shift = lshift_reg || rshift_reg;

    always_comb
    begin
        push_op.key   = key;
        push_op.shift = shift;
        push_op.caps  = caps_reg;
        push_op.combo = rctrl_reg && shift;
        push_op.ctrl  = lctrl_reg || rctrl_reg;
        push_op.alt   = lalt_reg || ralt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
            lshift_reg <= 1'b0;
            rshift_reg <= 1'b0;
            lctrl_reg  <= 1'b0;
            rctrl_reg  <= 1'b0;
            lalt_reg   <= 1'b0;
            ralt_reg   <= 1'b0;
            caps_reg   <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            lshift_reg <= lshift_next;
            rshift_reg <= rshift_next;
            lctrl_reg  <= lctrl_next;
            rctrl_reg  <= rctrl_next;
            lalt_reg   <= lalt_next;
            ralt_reg   <= ralt_next;
            caps_reg   <= caps_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/scadec_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module scadec_queue
    import scadec_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire key_op_t push_op,
    input  wire logic    pop,
    output logic         full,
    output logic         not_empty,
    output key_op_t      head_op
);

    key_op_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QDEPTH - 1))
            r = '0;
        else
            r = p + QPTR_W'(1);
        return r;
    endfunction

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

`default_nettype wire

FILE: sv/scadec_back.sv
`timescale 1ns / 1ps
`default_nettype none

module scadec_back
    import scadec_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_not_empty,
    input  wire key_op_t head_op,
    input  wire logic    char_stall,
    output logic         pop,
    output logic         char_valid,
    output logic [6:0]   char_code,
    output logic         event_kind,
    output logic         ctrl_held,
    output logic         alt_held
);

    logic        valid_reg, valid_next;
    logic [6:0]  code_reg;
    event_kind_t kind_reg;
    logic        ctrl_reg;
    logic        alt_reg;

    logic        load_ok;
    logic [6:0]  lo;
    logic [6:0]  hi;
    logic        is_letter;
    logic [6:0]  ch;
    logic        emit;
    event_kind_t kind;

    assign lo        = plain_char(head_op.key);
    assign hi        = shift_char(head_op.key);
    assign is_letter = (lo inside {[ASCII_LOWER_A:ASCII_LOWER_Z]});

    always_comb
    begin
        if (head_op.combo)
        begin
            ch   = lo;
            kind = EV_COMBO;
        end
        else
        begin
            kind = EV_CHAR;
            if (is_letter)
                ch = (head_op.shift != head_op.caps) ? hi : lo;
            else
                ch = head_op.shift ? hi : lo;
        end
    end

    // unmapped keys are dropped here; combos pass even with a zero code
    assign emit    = head_op.combo || (ch != 7'h00);
    assign load_ok = !valid_reg || !char_stall;
    assign pop     = q_not_empty && load_ok;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ok)
            valid_next = pop && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            code_reg <= ch;
            kind_reg <= kind;
            ctrl_reg <= head_op.ctrl;
            alt_reg  <= head_op.alt;
        end
    end

    assign char_valid = valid_reg;
    assign char_code  = code_reg;
    assign event_kind = kind_reg;
    assign ctrl_held  = ctrl_reg;
    assign alt_held   = alt_reg;

endmodule

`default_nettype wire

FILE: sv/scan_code_to_ascii_decoder_top.sv
// Channel   Valid        Stall        Payload
// scan      scan_valid   scan_stall   scan_byte[7:0]
// char      char_valid   char_stall   char_code[6:0], event_kind, ctrl_held, alt_held
//
// One byte a cycle is accepted while scan_stall is low; the front end updates its flags
// and writes the key into the two-entry queue, and a lookup fills the output register.
// Reset clears the prefix, modifier and caps-lock flags, the queue and the output valid.
// A stalled output holds the queue; scan_stall rises only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module scan_code_to_ascii_decoder_top
    import scadec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       scan_valid,
    output logic            scan_stall,
    input  wire logic [7:0] scan_byte,
    output logic            char_valid,
    input  wire logic       char_stall,
    output logic [6:0]      char_code,
    output logic            event_kind,
    output logic            ctrl_held,
    output logic            alt_held
);

    logic    q_full;
    logic    q_not_empty;
    logic    push;
    logic    pop;
    key_op_t push_op;
    key_op_t head_op;

    scadec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_byte  (scan_byte),
        .q_full     (q_full),
        .scan_stall (scan_stall),
        .push       (push),
        .push_op    (push_op)
    );

    scadec_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_op   (head_op)
    );

    scadec_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head_op     (head_op),
        .char_stall  (char_stall),
        .pop         (pop),
        .char_valid  (char_valid),
        .char_code   (char_code),
        .event_kind  (event_kind),
        .ctrl_held   (ctrl_held),
        .alt_held    (alt_held)
    );

endmodule

`default_nettype wire
